[sv/cpte_pkg.sv]
package cpte_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] MODE_LATIN1  = 2'd0;
  localparam logic [1:0] MODE_UTF8    = 2'd1;
  localparam logic [1:0] MODE_UTF16LE = 2'd2;
  localparam logic [1:0] MODE_UTF16BE = 2'd3;

  localparam logic [7:0] SUBST_CHAR = 8'h3f;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } entry_t;

  typedef struct packed {
    logic   wr_en;
    entry_t wr_data;
  } q_wr_t;

endpackage

[sv/cpte_front.sv]
module cpte_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [31:0]          code_point,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_data,
  input  logic                 q_full,
  output cpte_pkg::q_wr_t      q_wr
);

  logic [1:0]       mode;
  cpte_pkg::entry_t ent;
  logic             keep;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= cpte_pkg::MODE_LATIN1;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  always_comb begin
    ent.bytes    = '0;
    ent.last_idx = 2'd0;
    keep         = 1'b1;
    unique case (mode)
      cpte_pkg::MODE_LATIN1: begin
        ent.bytes[0] = (code_point <= 32'h0000_00ff) ? code_point[7:0] : cpte_pkg::SUBST_CHAR;
      end
      cpte_pkg::MODE_UTF8: begin
        if (code_point < 32'h0000_0080) begin
          ent.bytes[0] = code_point[7:0];
        end else if (code_point < 32'h0000_0800) begin
          ent.bytes[0]  = {3'b110, code_point[10:6]};
          ent.bytes[1]  = {2'b10, code_point[5:0]};
          ent.last_idx  = 2'd1;
        end else if (code_point < 32'h0001_0000) begin
          ent.bytes[0]  = {4'b1110, code_point[15:12]};
          ent.bytes[1]  = {2'b10, code_point[11:6]};
          ent.bytes[2]  = {2'b10, code_point[5:0]};
          ent.last_idx  = 2'd2;
        end else if (code_point < 32'h0020_0000) begin
          ent.bytes[0]  = {5'b11110, code_point[20:18]};
          ent.bytes[1]  = {2'b10, code_point[17:12]};
          ent.bytes[2]  = {2'b10, code_point[11:6]};
          ent.bytes[3]  = {2'b10, code_point[5:0]};
          ent.last_idx  = 2'd3;
        end else begin
          keep = 1'b0;
        end
      end
      cpte_pkg::MODE_UTF16LE: begin
        ent.bytes[0] = code_point[7:0];
        ent.bytes[1] = code_point[15:8];
        ent.last_idx = 2'd1;
      end
      default: begin
        ent.bytes[0] = code_point[15:8];
        ent.bytes[1] = code_point[7:0];
        ent.last_idx = 2'd1;
      end
    endcase
  end

  // drop items that encode to nothing
  assign q_wr.wr_en   = push && !q_full && keep;
  assign q_wr.wr_data = ent;

endmodule

[sv/cpte_queue.sv]
module cpte_queue #(
  parameter int unsigned DEPTH = cpte_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  cpte_pkg::q_wr_t  q_wr,
  output logic             full,
  input  logic             rd_en,
  output cpte_pkg::entry_t rd_data,
  output logic             q_empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cpte_pkg::entry_t mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CntW'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = q_wr.wr_en && !full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= q_wr.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("queue count above depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CntW'(DEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");
`endif

endmodule

[sv/cpte_back.sv]
module cpte_back (
  input  logic             clk,
  input  logic             rst,
  input  cpte_pkg::entry_t q_data,
  input  logic             q_empty,
  output logic             rd_en,
  output logic [7:0]       out_byte,
  output logic             last_byte,
  output logic             empty,
  input  logic             pop
);

  logic       out_valid;
  logic [1:0] idx;
  logic       load;
  logic       take;
  logic       is_last;

  assign empty   = !out_valid;
  assign load    = !out_valid || pop;
  assign take    = load && !q_empty;
  assign is_last = (idx == q_data.last_idx);
  assign rd_en   = take && is_last;

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte  <= q_data.bytes[idx];
      last_byte <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> out_valid)
    else $error("waiting item lost");
  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> (idx == 2'd0))
    else $error("byte index left mid item");
`endif

endmodule

[sv/code_point_text_encoder_core.sv]
// Character encoder: one code point in, up to four encoded bytes out.
// Input channel: code_point with push/full; an item is taken when push is
// high and full is low. Output channel: out_byte/last_byte with empty/pop;
// the oldest byte is shown while empty is low and taken when pop is high.
// last_byte marks the final byte of each code point.
// Configuration: cfg_data with cfg_valid/cfg_ready selects the encoding
// (0 latin1, 1 UTF-8, 2 UTF-16 LE, 3 UTF-16 BE); cfg_ready is always high.
// The first byte of an item passes the queue memory and then the single
// output register of the serializer before it is shown. The serializer
// gives one byte per cycle while pop is high and bytes are waiting, set by
// that output register. UTF-8 code points at or above 0x200000 give no
// bytes and are dropped at the input.
// A small queue between the encoder and the serializer lets the input keep
// going while the receiver stalls; full rises once it fills.
// Reset (rst, synchronous) empties the queue and the output register and
// selects latin1.
module code_point_text_encoder_core #(
  parameter int unsigned QUEUE_DEPTH = cpte_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] code_point,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);

  cpte_pkg::q_wr_t  q_wr;
  cpte_pkg::entry_t q_data;
  logic             q_empty;
  logic             rd_en;

  cpte_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .code_point (code_point),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_full     (full),
    .q_wr       (q_wr)
  );

  cpte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_wr    (q_wr),
    .full    (full),
    .rd_en   (rd_en),
    .rd_data (q_data),
    .q_empty (q_empty)
  );

  cpte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_data),
    .q_empty   (q_empty),
    .rd_en     (rd_en),
    .out_byte  (out_byte),
    .last_byte (last_byte),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

[tb/code_point_text_encoder_core_checker.sv]
`timescale 1ns / 1ps

module code_point_text_encoder_core_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [31:0] code_point,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_byte,
  input  logic        last_byte,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  output int          mismatches,
  output int          bytes_waiting
);

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } coded_byte_t;

  logic [1:0]  encoding;
  coded_byte_t coded_q[$];

  initial begin
    mismatches    = 0;
    bytes_waiting = 0;
    encoding      = cpte_pkg::MODE_LATIN1;
  end

  function automatic void add_byte(input logic [7:0] value, input logic last);
    coded_byte_t b;
    b.value = value;
    b.last  = last;
    coded_q.push_back(b);
  endfunction

  function automatic void encode_code_point(input logic [1:0] m, input logic [31:0] cp);
    case (m)
      cpte_pkg::MODE_LATIN1: begin
        add_byte((cp <= 32'hff) ? cp[7:0] : cpte_pkg::SUBST_CHAR, 1'b1);
      end
      cpte_pkg::MODE_UTF8: begin
        if (cp < 32'h80) begin
          add_byte(cp[7:0], 1'b1);
        end else if (cp < 32'h800) begin
          add_byte({3'b110, cp[10:6]}, 1'b0);
          add_byte({2'b10, cp[5:0]}, 1'b1);
        end else if (cp < 32'h10000) begin
          add_byte({4'b1110, cp[15:12]}, 1'b0);
          add_byte({2'b10, cp[11:6]}, 1'b0);
          add_byte({2'b10, cp[5:0]}, 1'b1);
        end else if (cp < 32'h200000) begin
          add_byte({5'b11110, cp[20:18]}, 1'b0);
          add_byte({2'b10, cp[17:12]}, 1'b0);
          add_byte({2'b10, cp[11:6]}, 1'b0);
          add_byte({2'b10, cp[5:0]}, 1'b1);
        end
      end
      cpte_pkg::MODE_UTF16LE: begin
        add_byte(cp[7:0], 1'b0);
        add_byte(cp[15:8], 1'b1);
      end
      default: begin
        add_byte(cp[15:8], 1'b0);
        add_byte(cp[7:0], 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk) begin : watch
    coded_byte_t head;
    if (rst) begin
      coded_q.delete();
      encoding = cpte_pkg::MODE_LATIN1;
    end else begin
      if (pop && !empty) begin
        if (coded_q.size() == 0) begin
          $error("out_byte with nothing pending: actual %02h last_byte %0b",
                 out_byte, last_byte);
          mismatches++;
        end else begin
          head = coded_q.pop_front();
          if (out_byte !== head.value) begin
            $error("out_byte expected %02h actual %02h", head.value, out_byte);
            mismatches++;
          end
          if (last_byte !== head.last) begin
            $error("last_byte expected %0b actual %0b", head.last, last_byte);
            mismatches++;
          end
        end
      end
      if (push && !full)
        encode_code_point(encoding, code_point);
      if (cfg_valid && cfg_ready)
        encoding = cfg_data;
    end
    bytes_waiting = coded_q.size();
  end

endmodule

[tb/code_point_text_encoder_core_tb.sv]
`timescale 1ns / 1ps

module code_point_text_encoder_core_tb;

  localparam int DIRECTED_COUNT = 22;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 20;

  localparam logic [31:0] DIRECTED_CP [DIRECTED_COUNT] = '{
    32'h0000_0000, 32'h0000_00ff, 32'h0000_0100, 32'hffff_ffff,
    32'h0000_0000, 32'h0000_007f, 32'h0000_0080, 32'h0000_07ff, 32'h0000_0800,
    32'h0000_ffff, 32'h0001_0000, 32'h001f_ffff, 32'h0020_0000, 32'hffff_ffff,
    32'h0000_a5c3, 32'h1234_5678, 32'hffff_ffff,
    32'h0000_0000, 32'ha5c3_f00f, 32'hffff_ffff,
    32'h5555_5555, 32'h0000_00aa
  };

  localparam logic [1:0] DIRECTED_MODE [DIRECTED_COUNT] = '{
    cpte_pkg::MODE_LATIN1, cpte_pkg::MODE_LATIN1, cpte_pkg::MODE_LATIN1,
    cpte_pkg::MODE_LATIN1,
    cpte_pkg::MODE_UTF8, cpte_pkg::MODE_UTF8, cpte_pkg::MODE_UTF8, cpte_pkg::MODE_UTF8,
    cpte_pkg::MODE_UTF8,
    cpte_pkg::MODE_UTF8, cpte_pkg::MODE_UTF8, cpte_pkg::MODE_UTF8, cpte_pkg::MODE_UTF8,
    cpte_pkg::MODE_UTF8,
    cpte_pkg::MODE_UTF16LE, cpte_pkg::MODE_UTF16LE, cpte_pkg::MODE_UTF16LE,
    cpte_pkg::MODE_UTF16BE, cpte_pkg::MODE_UTF16BE, cpte_pkg::MODE_UTF16BE,
    cpte_pkg::MODE_LATIN1, cpte_pkg::MODE_LATIN1
  };

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [31:0] code_point;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic        last_byte;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_data;
  int          mismatches;
  int          bytes_waiting;

  int          burst_left;
  logic [1:0]  current_mode;

  code_point_text_encoder_core dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .code_point (code_point),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .last_byte  (last_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  code_point_text_encoder_core_checker chk (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .code_point    (code_point),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .last_byte     (last_byte),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .bytes_waiting (bytes_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("code_point_text_encoder_core: mismatch");
    $finish;
  end

  // receiver: pick a new stall style each time the slot counter wraps
  initial begin : receiver
    int          style;
    int          slot;
    logic [31:0] pattern;
    pop   = 1'b0;
    slot  = 0;
    style = 0;
    pattern = '0;
    forever begin
      @(negedge clk);
      if (slot == 0) begin
        style   = $urandom_range(0, 3);
        pattern = $urandom;
      end
      case (style)
        0:       pop <= 1'b1;
        1:       pop <= pattern[slot];
        2:       pop <= pattern[slot] & pattern[(slot + 7) % 32];
        default: pop <= (slot == 31);
      endcase
      slot = (slot + 1) % 32;
    end
  end

  function automatic logic [31:0] random_code_point();
    logic [31:0] cp;
    case ($urandom_range(0, 7))
      0: cp = $urandom_range(0, 32'h7f);
      1: cp = $urandom_range(0, 32'hff);
      2: cp = $urandom_range(32'h80, 32'h7ff);
      3: cp = $urandom_range(32'h800, 32'hffff);
      4: cp = $urandom_range(32'h10000, 32'h1fffff);
      5: begin
        case ($urandom_range(0, 9))
          0: cp = 32'h7f;
          1: cp = 32'h80;
          2: cp = 32'h7ff;
          3: cp = 32'h800;
          4: cp = 32'hffff;
          5: cp = 32'h10000;
          6: cp = 32'h1fffff;
          7: cp = 32'h200000;
          8: cp = 32'hff;
          default: cp = 32'h100;
        endcase
      end
      default: cp = $urandom;
    endcase
    return cp;
  endfunction

  task automatic feed_code_point(input logic [31:0] cp);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    push       <= 1'b1;
    code_point <= cp;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    burst_left = 0;
    while (bytes_waiting != 0) @(negedge clk);
  endtask

  task automatic set_encoding(input logic [1:0] m);
    drain();
    // items without bytes never enter the queue; idle before changing the encoding
    repeat (6) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    current_mode = m;
  endtask

  initial begin : stimulus
    int         offset;
    logic [1:0] phase_mode;
    rst        = 1'b1;
    push       = 1'b0;
    code_point = '0;
    cfg_valid  = 1'b0;
    cfg_data   = cpte_pkg::MODE_LATIN1;
    burst_left = 0;
    current_mode = cpte_pkg::MODE_LATIN1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      if (DIRECTED_MODE[i] != current_mode || i == DIRECTED_COUNT - 2)
        set_encoding(DIRECTED_MODE[i]);
      feed_code_point(DIRECTED_CP[i]);
    end

    offset = $urandom_range(0, 3);
    for (int p = 0; p < PHASES; p++) begin
      phase_mode = 2'((p + offset) % 4);
      set_encoding(phase_mode);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 3 && i == ITEMS_PER_PHASE / 2)
          drain();
        feed_code_point(random_code_point());
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("code_point_text_encoder_core: match");
    end else begin
      $display("code_point_text_encoder_core: mismatch");
    end
    $finish;
  end

endmodule

[code_point_text_encoder_core.f]
sv/cpte_pkg.sv
sv/cpte_front.sv
sv/cpte_queue.sv
sv/cpte_back.sv
sv/code_point_text_encoder_core.sv
tb/code_point_text_encoder_core_checker.sv
tb/code_point_text_encoder_core_tb.sv
